// File: rtl/scu_pkg.sv
package scu_pkg;

  // field and datapath widths
  localparam int ANG_W   = 18;   // angle in 1/256 degree, signed
  localparam int T_W     = 17;   // reduced angle, 0 .. full turn - 1
  localparam int R_W     = 15;   // first-quadrant angle, 0 .. quarter turn
  localparam int Q_W     = 62;   // unsigned Q60 word with two integer bits
  localparam int FRAC_W  = 60;
  localparam int CHUNK_W = 21;   // digit width of the constant divider

  // pipeline shape
  localparam int SERIES_TERMS = 12;
  localparam int MUL_LAT      = 3;
  localparam int FRONT_LAT    = 6 + MUL_LAT;
  localparam int CELL_LAT     = MUL_LAT + 6;

  // angle constants, 1/256 degree
  localparam int FULL_TURN    = 92160;
  localparam int HALF_TURN    = 46080;
  localparam int QUARTER_TURN = 23040;
  localparam int THREE_QUARTER_TURN = 69120;

  // degree to radian: pi * 2^60 split into step and remainder per 1/256 degree
  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  localparam int RAD_STEP_W = 47;
  localparam int RAD_REM_W  = 16;
  localparam logic [RAD_STEP_W-1:0] RAD_STEP = RAD_STEP_W'(PI_Q60 / 64'(HALF_TURN));
  localparam logic [RAD_REM_W-1:0]  RAD_REM  = RAD_REM_W'(PI_Q60 % 64'(HALF_TURN));

  localparam logic FUNC_COS = 1'b1;

  typedef logic [Q_W-1:0] q60_t;

  localparam q60_t Q60_ONE = q60_t'(1) << FRAC_W;

  // data that rides alongside the series evaluation
  typedef struct packed {
    logic neg;
    q60_t theta;
    q60_t x2;
  } carry_t;

endpackage

// File: rtl/scu_mul.sv
module scu_mul (
  input  logic          clk,
  input  scu_pkg::q60_t a,
  input  scu_pkg::q60_t b,
  output scu_pkg::q60_t p
);

  // floor(a * b / 2^60) from four half-word products, three stages
  localparam int HW = scu_pkg::Q_W / 2;

  logic [2*HW-1:0] ll_r, lh_r, hl_r, hh_r;
  logic [2*HW-1:0] ll2_r, hh2_r;
  logic [2*HW:0]   mid_r;
  logic [4*HW-1:0] sum_nxt;
  scu_pkg::q60_t   p_r;

  always_ff @(posedge clk) begin
    ll_r <= a[HW-1:0]    * b[HW-1:0];
    lh_r <= a[HW-1:0]    * b[2*HW-1:HW];
    hl_r <= a[2*HW-1:HW] * b[HW-1:0];
    hh_r <= a[2*HW-1:HW] * b[2*HW-1:HW];
  end

  always_ff @(posedge clk) begin
    mid_r <= (2*HW+1)'(lh_r) + (2*HW+1)'(hl_r);
    ll2_r <= ll_r;
    hh2_r <= hh_r;
  end

  assign sum_nxt = {hh2_r, ll2_r} + ((4*HW)'(mid_r) << HW);

  always_ff @(posedge clk) begin
    p_r <= sum_nxt[scu_pkg::FRAC_W +: scu_pkg::Q_W];
  end

  assign p = p_r;

endmodule

// File: rtl/scu_front.sv
module scu_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_vld,
  input  logic                              in_func,
  input  logic signed [scu_pkg::ANG_W-1:0]  in_angle,
  output logic                              out_vld,
  output scu_pkg::carry_t                   out_carry
);

  localparam int EXT_W = scu_pkg::ANG_W + 2;
  localparam int T_W   = scu_pkg::T_W;
  localparam int R_W   = scu_pkg::R_W;
  localparam int Q_W   = scu_pkg::Q_W;
  localparam int LAT   = scu_pkg::FRONT_LAT;
  localparam int MLAT  = scu_pkg::MUL_LAT;

  localparam logic signed [EXT_W-1:0] FT_S  = EXT_W'(scu_pkg::FULL_TURN);
  localparam logic signed [EXT_W-1:0] FT2_S = EXT_W'(2 * scu_pkg::FULL_TURN);

  // remainder part: x / 46080 = (x >> 10) / 45, the odd factor by reciprocal
  localparam int P2_W    = scu_pkg::RAD_REM_W + R_W;
  localparam int DIV_SH  = 10;
  localparam int DIV_ODD = scu_pkg::HALF_TURN >> DIV_SH;
  localparam int Y_W     = P2_W - DIV_SH;
  localparam int L_ODD   = $clog2(DIV_ODD);
  localparam int S_ODD   = Y_W + L_ODD;
  localparam int QO_W    = Y_W + 1 - L_ODD;
  localparam logic [63:0] M_ODD =
    ((64'd1 << S_ODD) + 64'(DIV_ODD) - 64'd1) / 64'(DIV_ODD);

  logic [LAT-1:0]              vld_r;
  logic signed [EXT_W-1:0]     a_ext;
  logic [T_W-1:0]              t1_nxt, t1_r;
  logic                        func1_r;
  logic [T_W:0]                tsh;
  logic [T_W-1:0]              t2_nxt, t2_r;
  logic [1:0]                  quad;
  logic [T_W-1:0]              base;
  logic [R_W-1:0]              r0;
  logic [R_W-1:0]              r3_nxt, r3_r;
  logic                        neg3_r, neg4_r, neg5_r, neg6_r;
  scu_pkg::q60_t               p1_r, p1_5_r;
  logic [P2_W-1:0]             p2_r;
  logic [2*Y_W:0]              odd_prod;
  logic [QO_W-1:0]             q5_r;
  scu_pkg::q60_t               theta6_r;
  scu_pkg::q60_t               x2;
  logic                        neg_d_r   [MLAT];
  scu_pkg::q60_t               theta_d_r [MLAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], in_vld};
    end
  end

  // fold any 18-bit pattern into one turn
  assign a_ext = EXT_W'(in_angle);

  always_comb begin
    if (a_ext < -FT_S) begin
      t1_nxt = T_W'(a_ext + FT2_S);
    end else if (a_ext < 0) begin
      t1_nxt = T_W'(a_ext + FT_S);
    end else if (a_ext >= FT_S) begin
      t1_nxt = T_W'(a_ext - FT_S);
    end else begin
      t1_nxt = T_W'(a_ext);
    end
  end

  always_ff @(posedge clk) begin
    t1_r    <= t1_nxt;
    func1_r <= in_func;
  end

  // cosine as sine a quarter turn on
  always_comb begin
    tsh = {1'b0, t1_r} +
          ((func1_r == scu_pkg::FUNC_COS) ? (T_W+1)'(scu_pkg::QUARTER_TURN) : '0);
    if (tsh >= (T_W+1)'(scu_pkg::FULL_TURN)) begin
      t2_nxt = T_W'(tsh - (T_W+1)'(scu_pkg::FULL_TURN));
    end else begin
      t2_nxt = T_W'(tsh);
    end
  end

  always_ff @(posedge clk) begin
    t2_r <= t2_nxt;
  end

  // quadrant: mirror in odd ones, negate in the lower half-plane
  always_comb begin
    if (t2_r < T_W'(scu_pkg::QUARTER_TURN)) begin
      quad = 2'd0;
      base = '0;
    end else if (t2_r < T_W'(scu_pkg::HALF_TURN)) begin
      quad = 2'd1;
      base = T_W'(scu_pkg::QUARTER_TURN);
    end else if (t2_r < T_W'(scu_pkg::THREE_QUARTER_TURN)) begin
      quad = 2'd2;
      base = T_W'(scu_pkg::HALF_TURN);
    end else begin
      quad = 2'd3;
      base = T_W'(scu_pkg::THREE_QUARTER_TURN);
    end
    r0     = R_W'(t2_r - base);
    r3_nxt = quad[0] ? R_W'(scu_pkg::QUARTER_TURN) - r0 : r0;
  end

  always_ff @(posedge clk) begin
    r3_r   <= r3_nxt;
    neg3_r <= quad[1];
  end

  // radians in Q60
  always_ff @(posedge clk) begin
    p1_r   <= scu_pkg::RAD_STEP * r3_r;
    p2_r   <= scu_pkg::RAD_REM * r3_r;
    neg4_r <= neg3_r;
  end

  assign odd_prod = (2*Y_W+1)'(p2_r[P2_W-1:DIV_SH]) * (2*Y_W+1)'(M_ODD[Y_W:0]);

  always_ff @(posedge clk) begin
    q5_r   <= odd_prod[S_ODD +: QO_W];
    p1_5_r <= p1_r;
    neg5_r <= neg4_r;
  end

  always_ff @(posedge clk) begin
    theta6_r <= p1_5_r + Q_W'(q5_r);
    neg6_r   <= neg5_r;
  end

  scu_mul u_sq (
    .clk (clk),
    .a   (theta6_r),
    .b   (theta6_r),
    .p   (x2)
  );

  always_ff @(posedge clk) begin
    neg_d_r[0]   <= neg6_r;
    theta_d_r[0] <= theta6_r;
    for (int j = 1; j < MLAT; j++) begin
      neg_d_r[j]   <= neg_d_r[j-1];
      theta_d_r[j] <= theta_d_r[j-1];
    end
  end

  assign out_vld         = vld_r[LAT-1];
  assign out_carry.neg   = neg_d_r[MLAT-1];
  assign out_carry.theta = theta_d_r[MLAT-1];
  assign out_carry.x2    = x2;

endmodule

// File: rtl/scu_cell.sv
module scu_cell #(
  parameter int K = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  scu_pkg::carry_t in_carry,
  input  scu_pkg::q60_t   in_h,
  output logic            out_vld,
  output scu_pkg::carry_t out_carry,
  output scu_pkg::q60_t   out_h
);

  // one Horner step: h' = 1 - (x2 * h) / (2K (2K+1))
  localparam int Q_W   = scu_pkg::Q_W;
  localparam int C_W   = scu_pkg::CHUNK_W;
  localparam int LAT   = scu_pkg::CELL_LAT;
  localparam int D     = 2 * K * (2 * K + 1);
  localparam int L     = $clog2(D);
  localparam int N     = L + C_W;
  localparam int S     = N + L;
  localparam logic [63:0] MAGIC = ((64'd1 << S) + 64'(D) - 64'd1) / 64'(D);

  // exact floor(y / D) for any N-bit y
  function automatic logic [C_W-1:0] quo(input logic [N-1:0] y);
    logic [2*N:0] m;
    m = (2*N+1)'(y) * (2*N+1)'(MAGIC[N:0]);
    return m[S +: C_W];
  endfunction

  scu_pkg::q60_t   prod_p;
  logic [N-1:0]    y0_nxt, y0_r, y1_nxt, y1_r, y2_nxt;
  logic [C_W-1:0]  q0_r, q0b_r, q0c_r, q0d_r, q0e_r;
  logic [C_W-1:0]  q1_r, q1b_r, q1c_r, q2_r;
  logic [2*C_W-1:0] lo0_r, lo0b_r;
  logic [C_W-1:0]  lo1_r, lo1b_r;
  logic [L-1:0]    rem0_r, rem1_r;
  scu_pkg::q60_t   h_r;
  logic [LAT-1:0]  vld_r;
  scu_pkg::carry_t car_r [LAT];

  scu_mul u_mul (
    .clk (clk),
    .a   (in_carry.x2),
    .b   (in_h),
    .p   (prod_p)
  );

  // long division by D, three digits, remainder carried down
  assign y0_nxt = N'(prod_p[Q_W-1:2*C_W]);

  always_ff @(posedge clk) begin
    y0_r  <= y0_nxt;
    q0_r  <= quo(y0_nxt);
    lo0_r <= prod_p[2*C_W-1:0];
  end

  always_ff @(posedge clk) begin
    rem0_r <= L'(y0_r - N'(q0_r) * N'(D));
    q0b_r  <= q0_r;
    lo0b_r <= lo0_r;
  end

  assign y1_nxt = {rem0_r, lo0b_r[2*C_W-1:C_W]};

  always_ff @(posedge clk) begin
    y1_r  <= y1_nxt;
    q1_r  <= quo(y1_nxt);
    q0c_r <= q0b_r;
    lo1_r <= lo0b_r[C_W-1:0];
  end

  always_ff @(posedge clk) begin
    rem1_r <= L'(y1_r - N'(q1_r) * N'(D));
    q0d_r  <= q0c_r;
    q1b_r  <= q1_r;
    lo1b_r <= lo1_r;
  end

  assign y2_nxt = {rem1_r, lo1b_r};

  always_ff @(posedge clk) begin
    q2_r  <= quo(y2_nxt);
    q0e_r <= q0d_r;
    q1c_r <= q1b_r;
  end

  always_ff @(posedge clk) begin
    h_r <= Q_W'({1'b0, scu_pkg::Q60_ONE} - {q0e_r, q1c_r, q2_r});
  end

  // side data matched to the step latency
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    car_r[0] <= in_carry;
    for (int j = 1; j < LAT; j++) begin
      car_r[j] <= car_r[j-1];
    end
  end

  assign out_vld   = vld_r[LAT-1];
  assign out_carry = car_r[LAT-1];
  assign out_h     = h_r;

endmodule

// File: rtl/sine_cosine_unit_top.sv
// Sine/cosine unit: angle in 1/256 degree in, Q1.OUT_FRAC_BITS result out.
// Throughput: one transaction per cycle, busy is never raised; the receiver cannot
// stall, so the pipeline simply advances every cycle.
// Stages in the chain: 9-stage front end, 12 Horner cells of 9 stages, 3+1 at the end.
// Reset (rst_n, synchronous, active low) clears only the valid bits; no other state.
module sine_cosine_unit_top #(
  parameter int OUT_FRAC_BITS = 15
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_func,
  input  logic signed [scu_pkg::ANG_W-1:0]  in_angle_deg,
  output logic                              out_valid,
  output logic signed [OUT_FRAC_BITS:0]     out_trig_value
);

  localparam int Q_W    = scu_pkg::Q_W;
  localparam int FRAC_W = scu_pkg::FRAC_W;
  localparam int TERMS  = scu_pkg::SERIES_TERMS;
  localparam int MLAT   = scu_pkg::MUL_LAT;
  localparam int MAG_W  = OUT_FRAC_BITS + 3;
  localparam int RES_W  = OUT_FRAC_BITS + 1;

  // half an output LSB in Q60, for round-to-nearest with ties up
  localparam logic [Q_W:0] RND = (Q_W+1)'(1) << (FRAC_W - 1 - OUT_FRAC_BITS);

  logic                    vld_c   [TERMS+1];
  scu_pkg::carry_t         carry_c [TERMS+1];
  scu_pkg::q60_t           h_c     [TERMS+1];
  scu_pkg::q60_t           sin_q60;
  logic [MLAT-1:0]         vld_d_r;
  logic                    neg_d_r [MLAT];
  logic [Q_W:0]            rsum;
  logic [MAG_W-1:0]        mag;
  logic [RES_W-1:0]        magc;
  logic [RES_W-1:0]        res_nxt;
  logic                    out_valid_r;
  logic [RES_W-1:0]        out_trig_value_r;

  // Fully pipelined: every stage moves each cycle, so a new transaction is always taken.
  assign busy = 1'b0;

  // Front end: fold to one turn, cosine offset, quadrant fold, degrees to Q60
  // radians, then square for the series.
  scu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (start & ~busy),
    .in_func   (in_func),
    .in_angle  (in_angle_deg),
    .out_vld   (vld_c[0]),
    .out_carry (carry_c[0])
  );

  // Horner chain for sin(x)/x, highest term first; the running value enters at 1.0.
  assign h_c[0] = scu_pkg::Q60_ONE;

  for (genvar i = 0; i < TERMS; i++) begin : g_cell
    scu_cell #(
      .K (TERMS - i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_vld    (vld_c[i]),
      .in_carry  (carry_c[i]),
      .in_h      (h_c[i]),
      .out_vld   (vld_c[i+1]),
      .out_carry (carry_c[i+1]),
      .out_h     (h_c[i+1])
    );
  end

  // sin = x * h
  scu_mul u_fin (
    .clk (clk),
    .a   (carry_c[TERMS].theta),
    .b   (h_c[TERMS]),
    .p   (sin_q60)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_d_r <= '0;
    end else begin
      vld_d_r <= {vld_d_r[MLAT-2:0], vld_c[TERMS]};
    end
  end

  always_ff @(posedge clk) begin
    neg_d_r[0] <= carry_c[TERMS].neg;
    for (int j = 1; j < MLAT; j++) begin
      neg_d_r[j] <= neg_d_r[j-1];
    end
  end

  // Round the magnitude, clamp to 1.0, then apply the sign. -1.0 is exact;
  // +1.0 saturates to the largest positive code.
  always_comb begin
    rsum = (Q_W+1)'(sin_q60) + RND;
    mag  = rsum[Q_W:FRAC_W-OUT_FRAC_BITS];
    if (mag > (MAG_W'(1) << OUT_FRAC_BITS)) begin
      magc = RES_W'(1) << OUT_FRAC_BITS;
    end else begin
      magc = mag[RES_W-1:0];
    end
    if (neg_d_r[MLAT-1]) begin
      res_nxt = RES_W'(0) - magc;
    end else if (magc[OUT_FRAC_BITS]) begin
      res_nxt = {1'b0, {OUT_FRAC_BITS{1'b1}}};
    end else begin
      res_nxt = magc;
    end
  end

  // Output register: one-cycle strobe per transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_d_r[MLAT-1];
    end
  end

  always_ff @(posedge clk) begin
    out_trig_value_r <= res_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_trig_value = out_trig_value_r;

endmodule
